// ===== rtl/bst_pkg.sv =====
// Shared types, codes and constants of the bencode stream tokenizer.
`default_nettype none

package bst_pkg;

    // Sizing
    localparam int MAX_DEPTH   = 32;
    localparam int LENGTH_BITS = 32;
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
    localparam int STACK_AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Port field widths
    localparam int INT_W    = 64;
    localparam int STRLEN_W = 32;
    localparam int NEST_W   = 6;

    // Characters of the bencode grammar
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [1:0] {
        MODE_VALUE = 2'd0,
        MODE_INT   = 2'd1,
        MODE_LEN   = 2'd2,
        MODE_DATA  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_LIST = 2'd1,
        KIND_DKEY = 2'd2,
        KIND_DVAL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        DIGS_NONE = 2'd0,
        DIGS_NZ   = 2'd1,
        DIGS_ZERO = 2'd2
    } digs_t;

    typedef enum logic [2:0] {
        TOK_INT     = 3'd0,
        TOK_STR_HDR = 3'd1,
        TOK_STR_BYTE = 3'd2,
        TOK_LIST    = 3'd3,
        TOK_DICT    = 3'd4,
        TOK_CLOSE   = 3'd5,
        TOK_ERROR   = 3'd6
    } token_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_BAD_TYPE   = 4'd1,
        ERR_MINUS      = 4'd2,
        ERR_LEAD_ZERO  = 4'd3,
        ERR_MINUS_ZERO = 4'd4,
        ERR_INT_CHAR   = 4'd5,
        ERR_INT_RANGE  = 4'd6,
        ERR_LEN_CHAR   = 4'd7,
        ERR_TOO_DEEP   = 4'd8,
        ERR_LEN_OVF    = 4'd9
    } err_t;

    typedef struct packed {
        token_t                    kind;
        logic signed [INT_W-1:0]   int_value;
        logic [STRLEN_W-1:0]       string_length;
        logic [7:0]                payload_byte;
        logic                      last;
        logic                      key;
        logic [NEST_W-1:0]         nest;
        err_t                      err;
    } result_t;

    // Parser -> stack: top-of-stack update, spill of old top on push, read of entry below
    typedef struct packed {
        logic                top_we;
        kind_t               top_kind;
        logic                below_we;
        logic [STACK_AW-1:0] below_addr;
        kind_t               below_kind;
        logic [STACK_AW-1:0] rd_addr;
    } stack_ctrl_t;

    // Dict alternates key/value once a value completes
    function automatic kind_t kind_flip(kind_t k);
        kind_t r;
        case (k)
            KIND_DKEY: r = KIND_DVAL;
            KIND_DVAL: r = KIND_DKEY;
            default:   r = k;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bencode_stream_tokenizer_core.sv =====
// Top level of the bencode stream tokenizer: input word register, parser, result register.
//
//  channel | dir | handshake         | word contents
//  s_      | in  | s_valid/s_ready   | s_data_byte: one raw byte of the bencoded stream
//  m_      | out | m_valid/m_ready   | one token: kind, integer, length, data byte, flags,
//          |     |                   | nesting level, error code
//
// Throughput is one byte per cycle while the result register is free or draining. A byte
// passes the input word register and then the result register before its token reaches m_.
// A byte is registered, then parsed against the state registers once the result register is
// free or draining, and its token (if any) lands in the result register.
// Reset (aresetn, synchronous, low) returns to top level with an empty stack; no
// clearing pass is needed since the stack is only read below the tracked depth.
// When m_ready holds low with a token waiting, the registered byte waits too and s_ready
// drops once that register is full; bytes that yield no token still move when m_ is free.
`default_nettype none

module bencode_stream_tokenizer_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_data_byte,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [2:0]                           m_token_kind,
    output logic signed [bst_pkg::INT_W-1:0]     m_int_value,
    output logic [bst_pkg::STRLEN_W-1:0]         m_string_length,
    output logic [7:0]                           m_payload_byte,
    output logic                                 m_last_of_string,
    output logic                                 m_is_dict_key,
    output logic [bst_pkg::NEST_W-1:0]           m_nest_level,
    output logic [3:0]                           m_error_code
);
    import bst_pkg::*;

    // Input word register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Result register
    logic        out_valid_reg;
    result_t     out_reg;

    logic        fire;
    logic        emit;
    result_t     res;
    stack_ctrl_t stk;
    kind_t       top_kind;
    kind_t       under_kind;

    // Parse step runs when a byte is held and the result slot is free or draining
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= res;
        end
    end

    bst_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (fire),
        .data_byte  (in_byte_reg),
        .top_kind   (top_kind),
        .under_kind (under_kind),
        .stk        (stk),
        .emit       (emit),
        .res        (res)
    );

    bst_stack u_stack (
        .aclk       (aclk),
        .ctrl       (stk),
        .top_kind   (top_kind),
        .under_kind (under_kind)
    );

    assign m_valid          = out_valid_reg;
    assign m_token_kind     = out_reg.kind;
    assign m_int_value      = out_reg.int_value;
    assign m_string_length  = out_reg.string_length;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_last_of_string = out_reg.last;
    assign m_is_dict_key    = out_reg.key;
    assign m_nest_level     = out_reg.nest;
    assign m_error_code     = out_reg.err;

endmodule

`default_nettype wire

// ===== rtl/bst_stack.sv =====
// Container kind stack: registered top entry plus array of entries beneath it.
`default_nettype none

module bst_stack (
    input  wire logic                 aclk,
    input  wire bst_pkg::stack_ctrl_t ctrl,
    output bst_pkg::kind_t            top_kind,
    output bst_pkg::kind_t            under_kind
);
    import bst_pkg::*;

    kind_t top_reg;
    kind_t below_reg [MAX_DEPTH];

    // Contents are undefined until written; depth tracking guards every read.
    always_ff @(posedge aclk) begin
        if (ctrl.top_we) begin
            top_reg <= ctrl.top_kind;
        end
        if (ctrl.below_we) begin
            below_reg[ctrl.below_addr] <= ctrl.below_kind;
        end
    end

    assign top_kind   = top_reg;
    assign under_kind = below_reg[ctrl.rd_addr];

endmodule

`default_nettype wire

// ===== rtl/bst_parser.sv =====
// Tokenizer state machine: consumes one byte per step, yields at most one token.
`default_nettype none

module bst_parser (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    input  wire bst_pkg::kind_t        top_kind,
    input  wire bst_pkg::kind_t        under_kind,
    output bst_pkg::stack_ctrl_t       stk,
    output logic                       emit,
    output bst_pkg::result_t           res
);
    import bst_pkg::*;

    mode_t                  mode_reg,  mode_next;
    logic [INT_W-1:0]       mag_reg,   mag_next;
    logic                   neg_reg,   neg_next;
    digs_t                  digs_reg,  digs_next;
    logic [LENGTH_BITS-1:0] len_reg,   len_next;
    logic [LENGTH_BITS-1:0] rem_reg,   rem_next;
    logic                   key_reg,   key_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;

    logic                   digit;
    logic [3:0]             dval;
    kind_t                  k_cur;
    kind_t                  k_pop;
    logic [DEPTH_W-1:0]     depth_m1;
    logic [DEPTH_W-1:0]     depth_m2;
    logic [INT_W+3:0]       mag_prod;
    logic [LENGTH_BITS+3:0] len_prod;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   int_over;
    logic                   fail_en;
    err_t                   fail_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_VALUE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            digs_reg  <= DIGS_NONE;
            len_reg   <= '0;
            rem_reg   <= '0;
            key_reg   <= 1'b0;
            depth_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            digs_reg  <= digs_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            key_reg   <= key_next;
            depth_reg <= depth_next;
        end
    end

    // Datapath helpers: x*10+d as shift-add, overflow seen in the top nibble
    assign digit    = (data_byte inside {[CH_0:CH_9]});
    assign dval     = digit ? 4'(data_byte - CH_0) : 4'd0;
    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign depth_m2 = depth_reg - DEPTH_W'(2);
    assign k_cur    = (depth_reg == '0) ? KIND_NONE : top_kind;
    assign k_pop    = (depth_m1 == '0) ? KIND_NONE : under_kind;
    assign mag_prod = ({4'd0, mag_reg} << 3) + ({4'd0, mag_reg} << 1) + (INT_W+4)'(dval);
    assign len_prod = ({4'd0, len_reg} << 3) + ({4'd0, len_reg} << 1)
                    + (LENGTH_BITS+4)'(dval);
    assign rem_dec  = (rem_reg != '0) ? rem_reg - LENGTH_BITS'(1) : rem_reg;
    // Negative side may reach 2^63, positive side stops at 2^63-1
    assign int_over = neg_reg ? (mag_reg[INT_W-1] && (mag_reg[INT_W-2:0] != '0))
                              : mag_reg[INT_W-1];

    always_comb begin
        mode_next  = mode_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        digs_next  = digs_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        key_next   = key_reg;
        depth_next = depth_reg;
        fail_en    = 1'b0;
        fail_code  = ERR_NONE;
        emit       = 1'b0;
        res        = '0;
        res.kind   = TOK_INT;
        res.err    = ERR_NONE;
        stk            = '0;
        stk.top_kind   = KIND_NONE;
        stk.below_kind = KIND_NONE;
        stk.below_addr = depth_m1[STACK_AW-1:0];
        stk.rd_addr    = depth_m2[STACK_AW-1:0];

        case (mode_reg)
            MODE_INT: begin
                if (data_byte == CH_E) begin
                    if (digs_reg == DIGS_NONE || int_over) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_INT_RANGE;
                    end else begin
                        emit          = 1'b1;
                        res.kind      = TOK_INT;
                        res.int_value = neg_reg ? -mag_reg : mag_reg;
                        mode_next     = MODE_VALUE;
                        key_next      = 1'b0;
                        stk.top_we    = 1'b1;
                        stk.top_kind  = kind_flip(k_cur);
                    end
                end else if (data_byte == CH_MINUS) begin
                    if (neg_reg || digs_reg != DIGS_NONE) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_MINUS;
                    end else begin
                        neg_next = 1'b1;
                    end
                end else if (!digit) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_INT_CHAR;
                end else if (digs_reg == DIGS_ZERO) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_LEAD_ZERO;
                end else if (digs_reg == DIGS_NONE && neg_reg && dval == 4'd0) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_MINUS_ZERO;
                end else begin
                    if (digs_reg == DIGS_NONE) begin
                        digs_next = (dval == 4'd0) ? DIGS_ZERO : DIGS_NZ;
                    end
                    // Saturate; range error is reported at the closing byte
                    mag_next = (mag_prod[INT_W+3:INT_W] != 4'd0) ? '1 : mag_prod[INT_W-1:0];
                end
            end
            MODE_LEN: begin
                if (data_byte == CH_COLON) begin
                    emit              = 1'b1;
                    res.kind          = TOK_STR_HDR;
                    res.string_length = STRLEN_W'(len_reg);
                    res.key           = key_reg;
                    if (len_reg == '0) begin
                        res.last     = 1'b1;
                        mode_next    = MODE_VALUE;
                        key_next     = 1'b0;
                        stk.top_we   = 1'b1;
                        stk.top_kind = kind_flip(k_cur);
                    end else begin
                        rem_next  = len_reg;
                        mode_next = MODE_DATA;
                    end
                end else if (!digit) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_LEN_CHAR;
                end else if (len_prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_LEN_OVF;
                end else begin
                    len_next = len_prod[LENGTH_BITS-1:0];
                end
            end
            MODE_DATA: begin
                emit             = 1'b1;
                res.kind         = TOK_STR_BYTE;
                res.payload_byte = data_byte;
                res.key          = key_reg;
                rem_next         = rem_dec;
                res.last         = (rem_dec == '0);
                if (rem_dec == '0) begin
                    mode_next    = MODE_VALUE;
                    key_next     = 1'b0;
                    stk.top_we   = 1'b1;
                    stk.top_kind = kind_flip(k_cur);
                end
            end
            default: begin
                // Expecting a value, a dict key or a close
                mode_next = MODE_VALUE;
                if (data_byte == CH_E) begin
                    if (k_cur == KIND_LIST || k_cur == KIND_DKEY) begin
                        emit         = 1'b1;
                        res.kind     = TOK_CLOSE;
                        depth_next   = depth_m1;
                        key_next     = 1'b0;
                        stk.top_we   = 1'b1;
                        stk.top_kind = kind_flip(k_pop);
                    end else begin
                        fail_en   = 1'b1;
                        fail_code = ERR_BAD_TYPE;
                    end
                end else if (digit) begin
                    key_next  = (k_cur == KIND_DKEY);
                    len_next  = LENGTH_BITS'(dval);
                    mode_next = MODE_LEN;
                end else if (k_cur == KIND_DKEY) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_LEN_CHAR;
                end else if (data_byte == CH_I) begin
                    mag_next  = '0;
                    neg_next  = 1'b0;
                    digs_next = DIGS_NONE;
                    mode_next = MODE_INT;
                end else if (data_byte == CH_L || data_byte == CH_D) begin
                    if (depth_reg >= DEPTH_W'(MAX_DEPTH)) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_TOO_DEEP;
                    end else begin
                        emit       = 1'b1;
                        res.kind   = (data_byte == CH_L) ? TOK_LIST : TOK_DICT;
                        depth_next = depth_reg + DEPTH_W'(1);
                        // Spill old top below, new kind becomes top
                        stk.below_we   = (depth_reg != '0);
                        stk.below_kind = top_kind;
                        stk.top_we     = 1'b1;
                        stk.top_kind   = (data_byte == CH_L) ? KIND_LIST : KIND_DKEY;
                    end
                end else begin
                    fail_en   = 1'b1;
                    fail_code = ERR_BAD_TYPE;
                end
            end
        endcase

        if (fail_en) begin
            mode_next      = MODE_VALUE;
            mag_next       = '0;
            neg_next       = 1'b0;
            digs_next      = DIGS_NONE;
            len_next       = '0;
            rem_next       = '0;
            key_next       = 1'b0;
            depth_next     = '0;
            stk.top_we     = 1'b0;
            stk.below_we   = 1'b0;
            emit           = 1'b1;
            res            = '0;
            res.kind       = TOK_ERROR;
            res.err        = fail_code;
        end

        if (!step) begin
            stk.top_we   = 1'b0;
            stk.below_we = 1'b0;
            emit         = 1'b0;
        end

        res.nest = NEST_W'(depth_next);
    end

endmodule

`default_nettype wire

// ===== dv/tb_bencode_stream_tokenizer_core.sv =====
// Self-checking testbench of the bencode stream tokenizer core: directed and random byte streams.
`default_nettype none

module tb_bencode_stream_tokenizer_core;
    import bst_pkg::*;

    // Largest length that the length digits may build up to
    localparam logic [63:0] LEN_CAP = (64'd1 << LENGTH_BITS) - 64'd1;
    // Result path is two stages deep; settle margin after the last token
    localparam int SETTLE_CYCLES = 10;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_data_byte = 8'h00;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic [2:0]              m_token_kind;
    logic signed [INT_W-1:0] m_int_value;
    logic [STRLEN_W-1:0]     m_string_length;
    logic [7:0]              m_payload_byte;
    logic                    m_last_of_string;
    logic                    m_is_dict_key;
    logic [NEST_W-1:0]       m_nest_level;
    logic [3:0]              m_error_code;

    bencode_stream_tokenizer_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_int_value      (m_int_value),
        .m_string_length  (m_string_length),
        .m_payload_byte   (m_payload_byte),
        .m_last_of_string (m_last_of_string),
        .m_is_dict_key    (m_is_dict_key),
        .m_nest_level     (m_nest_level),
        .m_error_code     (m_error_code)
    );

    always #2 aclk = ~aclk;

    // Idle controls: percent of cycles the sender holds off / the receiver stalls
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    int fail_count = 0;
    int bytes_accepted = 0;

    // Tokens the parser mirror has predicted and the m_ side has not delivered yet
    result_t pending_tokens[$];

    // Bytes of the stream under construction in the random tests
    logic [7:0] doc_bytes[$];

    // ------------------------------------------------------------------
    // Parser mirror: own copy of the tokenizer state
    // ------------------------------------------------------------------
    mode_t       tk_mode;
    logic [63:0] tk_mag;        // integer magnitude, saturating
    logic        tk_neg;
    digs_t       tk_digits;     // none / nonzero lead / exactly "0"
    logic [63:0] tk_len;        // length digits so far
    logic [63:0] tk_left;       // data bytes still to come
    logic        tk_key;        // current string is a dict key
    int          tk_depth;
    kind_t       tk_stack [0:MAX_DEPTH-1];

    function automatic void clear_mirror();
        tk_mode   = MODE_VALUE;
        tk_mag    = '0;
        tk_neg    = 1'b0;
        tk_digits = DIGS_NONE;
        tk_len    = '0;
        tk_left   = '0;
        tk_key    = 1'b0;
        tk_depth  = 0;
    endfunction

    function automatic kind_t top_of_nest();
        if (tk_depth == 0 || tk_depth > MAX_DEPTH) return KIND_NONE;
        return tk_stack[tk_depth-1];
    endfunction

    // A value just finished: back to value mode, and a dict swaps key/value slot
    function automatic void finish_value();
        kind_t k;
        k = top_of_nest();
        tk_mode = MODE_VALUE;
        tk_key  = 1'b0;
        if (k == KIND_DKEY) tk_stack[tk_depth-1] = KIND_DVAL;
        else if (k == KIND_DVAL) tk_stack[tk_depth-1] = KIND_DKEY;
    endfunction

    function automatic void expect_token(input token_t kind, input logic [63:0] ival,
                                         input logic [31:0] slen, input logic [7:0] pay,
                                         input logic fin, input logic key, input err_t code);
        result_t t;
        t.kind          = kind;
        t.int_value     = ival;
        t.string_length = slen;
        t.payload_byte  = pay;
        t.last          = fin;
        t.key           = key;
        t.nest          = NEST_W'(tk_depth);
        t.err           = code;
        pending_tokens.push_back(t);
    endfunction

    // Every error wipes the stack; the token reports depth zero
    function automatic void expect_error(input err_t code);
        clear_mirror();
        expect_token(TOK_ERROR, 64'd0, 32'd0, 8'd0, 1'b0, 1'b0, code);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b);
        logic        is_digit;
        logic [63:0] dv;
        logic [63:0] lim;
        logic        key_f;
        logic        fin;
        kind_t       k;
        is_digit = (b >= CH_0 && b <= CH_9);
        dv = is_digit ? 64'(b - CH_0) : 64'd0;
        case (tk_mode)
            MODE_INT: begin
                if (b == CH_E) begin
                    lim = tk_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    if (tk_digits == DIGS_NONE || tk_mag > lim) begin
                        expect_error(ERR_INT_RANGE);
                    end else begin
                        finish_value();
                        expect_token(TOK_INT, tk_neg ? (64'd0 - tk_mag) : tk_mag,
                                     32'd0, 8'd0, 1'b0, 1'b0, ERR_NONE);
                    end
                end else if (b == CH_MINUS) begin
                    if (tk_neg || tk_digits != DIGS_NONE) expect_error(ERR_MINUS);
                    else tk_neg = 1'b1;
                end else if (!is_digit) begin
                    expect_error(ERR_INT_CHAR);
                end else if (tk_digits == DIGS_ZERO) begin
                    expect_error(ERR_LEAD_ZERO);
                end else if (tk_digits == DIGS_NONE && tk_neg && dv == 0) begin
                    expect_error(ERR_MINUS_ZERO);
                end else begin
                    if (tk_digits == DIGS_NONE) tk_digits = (dv == 0) ? DIGS_ZERO : DIGS_NZ;
                    // magnitude sticks at all ones once it overflows
                    if (tk_mag > (64'hFFFF_FFFF_FFFF_FFFF - dv) / 64'd10) tk_mag = '1;
                    else tk_mag = tk_mag * 64'd10 + dv;
                end
            end
            MODE_LEN: begin
                if (b == CH_COLON) begin
                    key_f = tk_key;
                    if (tk_len == 0) begin
                        finish_value();
                        expect_token(TOK_STR_HDR, 64'd0, 32'd0, 8'd0, 1'b1, key_f, ERR_NONE);
                    end else begin
                        tk_left = tk_len;
                        tk_mode = MODE_DATA;
                        expect_token(TOK_STR_HDR, 64'd0, tk_len[31:0], 8'd0, 1'b0, key_f,
                                     ERR_NONE);
                    end
                end else if (!is_digit) begin
                    expect_error(ERR_LEN_CHAR);
                end else if (tk_len > (LEN_CAP - dv) / 64'd10) begin
                    expect_error(ERR_LEN_OVF);
                end else begin
                    tk_len = tk_len * 64'd10 + dv;
                end
            end
            MODE_DATA: begin
                key_f = tk_key;
                if (tk_left > 0) tk_left = tk_left - 64'd1;
                fin = (tk_left == 0);
                if (fin) finish_value();
                expect_token(TOK_STR_BYTE, 64'd0, 32'd0, b, fin, key_f, ERR_NONE);
            end
            default: begin
                k = top_of_nest();
                tk_mode = MODE_VALUE;
                if (b == CH_E) begin
                    if (k == KIND_LIST || k == KIND_DKEY) begin
                        tk_depth--;
                        finish_value();
                        expect_token(TOK_CLOSE, 64'd0, 32'd0, 8'd0, 1'b0, 1'b0, ERR_NONE);
                    end else begin
                        expect_error(ERR_BAD_TYPE);
                    end
                end else if (is_digit) begin
                    tk_key  = (k == KIND_DKEY);
                    tk_len  = dv;
                    tk_mode = MODE_LEN;
                end else if (k == KIND_DKEY) begin
                    // only a string may stand in key position
                    expect_error(ERR_LEN_CHAR);
                end else if (b == CH_I) begin
                    tk_mag    = '0;
                    tk_neg    = 1'b0;
                    tk_digits = DIGS_NONE;
                    tk_mode   = MODE_INT;
                end else if (b == CH_L || b == CH_D) begin
                    if (tk_depth >= MAX_DEPTH) begin
                        expect_error(ERR_TOO_DEEP);
                    end else begin
                        tk_stack[tk_depth] = (b == CH_L) ? KIND_LIST : KIND_DKEY;
                        tk_depth++;
                        expect_token((b == CH_L) ? TOK_LIST : TOK_DICT, 64'd0, 32'd0, 8'd0,
                                     1'b0, 1'b0, ERR_NONE);
                    end
                end else begin
                    expect_error(ERR_BAD_TYPE);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // s_ side: one word per call, with random hold-off before it
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        // the word moves at the first edge that sees s_ready high
        do @(posedge aclk); while (!s_ready);
        tokenize_byte(b);
        bytes_accepted++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_doc();
        while (doc_bytes.size() != 0) send_byte(doc_bytes.pop_front());
    endtask

    // ------------------------------------------------------------------
    // m_ side: random back-pressure and the token checker
    // ------------------------------------------------------------------
    always @(posedge aclk) m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    function automatic void check_field(input string fname, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tokens.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected token, expected none, actual kind %0d err %0d",
                         $time, m_token_kind, m_error_code);
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 64'(want.kind), 64'(m_token_kind));
                check_field("int_value", want.int_value, m_int_value);
                check_field("string_length", 64'(want.string_length), 64'(m_string_length));
                check_field("payload_byte", 64'(want.payload_byte), 64'(m_payload_byte));
                check_field("last_of_string", 64'(want.last), 64'(m_last_of_string));
                check_field("is_dict_key", 64'(want.key), 64'(m_is_dict_key));
                check_field("nest_level", 64'(want.nest), 64'(m_nest_level));
                check_field("error_code", 64'(want.err), 64'(m_error_code));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random stream builders
    // ------------------------------------------------------------------
    function automatic void push_decimal(input logic [63:0] mag);
        logic [7:0] digs [0:19];
        int         n;
        n = 0;
        do begin
            digs[n] = CH_0 + 8'(mag % 64'd10);
            mag = mag / 64'd10;
            n++;
        end while (mag != 0);
        for (int i = n - 1; i >= 0; i--) doc_bytes.push_back(digs[i]);
    endfunction

    // Well-formed integer: small, wide or at the signed 64-bit extremes
    function automatic void add_int();
        logic [63:0] mag;
        logic        neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0, 1, 2: mag = 64'($urandom_range(0, 999));
            3, 4:    mag = {$urandom, $urandom} >> $urandom_range(1, 63);
            default: mag = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
        if (mag == 0) neg = 1'b0;
        doc_bytes.push_back(CH_I);
        if (neg) doc_bytes.push_back(CH_MINUS);
        push_decimal(mag);
        doc_bytes.push_back(CH_E);
    endfunction

    // Mostly short strings with full-range content; a leading zero now and then
    function automatic void add_string(input bit short_one);
        int n;
        if (!short_one && $urandom_range(0, 7) == 0) n = $urandom_range(9, 40);
        else n = $urandom_range(0, short_one ? 6 : 8);
        if ($urandom_range(0, 7) == 0) doc_bytes.push_back(CH_0);
        push_decimal(64'(n));
        doc_bytes.push_back(CH_COLON);
        repeat (n) doc_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One top-level value; now and then a deep chain that comes near or past the depth limit
    function automatic void build_document();
        kind_t lvl [0:MAX_DEPTH+1];
        int    depth;
        int    budget;
        int    max_nest;
        int    r;
        bit    deep;
        depth = 0;
        deep  = ($urandom_range(0, 19) == 0);
        if (deep) begin
            max_nest = $urandom_range(MAX_DEPTH - 2, MAX_DEPTH + 1);
            budget   = max_nest + 3;
        end else begin
            max_nest = 4;
            budget   = $urandom_range(0, 14);
        end
        do begin
            if (depth > 0 && lvl[depth-1] != KIND_DVAL &&
                (budget == 0 || (!deep && $urandom_range(0, 3) == 0))) begin
                doc_bytes.push_back(CH_E);
                depth--;
                if (depth > 0 && lvl[depth-1] == KIND_DVAL) lvl[depth-1] = KIND_DKEY;
            end else if (depth > 0 && lvl[depth-1] == KIND_DKEY) begin
                add_string(1'b1);
                lvl[depth-1] = KIND_DVAL;
            end else begin
                if (budget > 0) budget--;
                r = $urandom_range(0, 3);
                if ((deep || r >= 2) && depth < max_nest && budget > 0) begin
                    if (r[0]) begin
                        doc_bytes.push_back(CH_D);
                        lvl[depth] = KIND_DKEY;
                    end else begin
                        doc_bytes.push_back(CH_L);
                        lvl[depth] = KIND_LIST;
                    end
                    depth++;
                end else begin
                    if (r[0]) add_int();
                    else add_string(1'b0);
                    if (depth > 0) lvl[depth-1] = (lvl[depth-1] == KIND_DVAL) ? KIND_DKEY
                                                                               : lvl[depth-1];
                end
            end
        end while (depth > 0);
    endfunction

    // Garbage bytes; no digit runs, so no runaway string lengths
    function automatic void add_noise();
        logic [7:0] b;
        logic       prev_digit;
        prev_digit = 1'b0;
        repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (prev_digit && b >= CH_0 && b <= CH_9) b = CH_COLON;
            prev_digit = (b >= CH_0 && b <= CH_9);
            doc_bytes.push_back(b);
        end
    endfunction

    // Get back to top level after broken input: finish short strings, force an error otherwise
    task automatic resync();
        while (!(tk_mode == MODE_VALUE && tk_depth == 0) &&
               !(tk_mode == MODE_DATA && tk_left >= 64'd4096)) begin
            if (tk_mode == MODE_DATA) send_byte(8'($urandom_range(0, 255)));
            else send_byte(8'hFF);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_integers();
        send_text("i0e");
        send_text("i-9223372036854775808e");
        send_text("i9223372036854775807e");
        send_text("i42ei-7e");              // values back to back at top level
    endtask

    task automatic test_integer_errors();
        send_text("i9223372036854775808e");  // one past max
        send_text("i-9223372036854775809e"); // one past min
        send_text("ie");                     // empty
        send_text("i-e");                    // sign only
        send_text("i99999999999999999999e"); // saturated magnitude, range error at close
        send_text("i99999999999999999999z"); // saturated, bad char wins
        send_text("i1-");
        send_text("i--");
        send_text("i01");
        send_text("i-0");
        send_text("i1x");
    endtask

    task automatic test_strings();
        send_text("0:");
        send_text("3:");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_COLON);
        send_text("007:abcdefg");            // leading zeros in a length are fine
        send_text("4:spam");
    endtask

    task automatic test_length_errors();
        send_text("4294967296");             // overflow on the last digit
        send_text("4294967295e");            // max length held, then a bad length char
        send_text("12x");
    endtask

    task automatic test_containers();
        send_text("le");
        send_text("de");
        send_text("li1e4:spame");
        send_text("d3:cow3:moo4:spaml1:a1:bee");
        send_text("d1:kd1:ki0eee");
        send_text("lde");
    endtask

    task automatic test_structure_errors();
        send_text("e");                      // close at top level
        send_text("d3:keye");                // close where a dict value belongs
        send_text("dx");                     // non-digit as key
        send_text("d:");                     // colon as key
        send_text("di1e");
        send_text("d1x");
        send_text("l:");
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_nesting_limit();
        repeat (MAX_DEPTH) send_byte(CH_L);
        send_byte(CH_D);                     // one level too deep
        repeat (MAX_DEPTH) send_byte(CH_L);
        repeat (MAX_DEPTH) send_byte(CH_E);
        repeat (MAX_DEPTH) send_text("d1:a");
        send_byte(CH_L);                     // too deep from a dict value slot
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_bytes);
        int start;
        bit broken;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start = bytes_accepted;
        while (bytes_accepted - start < n_bytes) begin
            broken = 1'b0;
            build_document();
            // corrupt a byte or cut the value short
            if ($urandom_range(0, 5) == 0) begin
                r_corrupt();
                broken = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                add_noise();
                broken = 1'b1;
            end
            send_doc();
            if (broken && $urandom_range(0, 1)) resync();
        end
    endtask

    function automatic void r_corrupt();
        int pos;
        pos = $urandom_range(0, doc_bytes.size() - 1);
        if ($urandom_range(0, 1)) doc_bytes[pos] = 8'($urandom_range(0, 255));
        else while (doc_bytes.size() > pos) doc_bytes.delete(doc_bytes.size() - 1);
    endfunction

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_mirror();
        for (int i = 0; i < MAX_DEPTH; i++) tk_stack[i] = KIND_NONE;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part with the handshake always open
        test_integers();
        test_integer_errors();
        test_strings();
        test_length_errors();
        test_containers();
        test_structure_errors();
        test_nesting_limit();

        // random streams under each idle pattern
        test_random_traffic(0, 0, 180);
        test_random_traffic(72, 0, 170);
        test_random_traffic(0, 72, 170);
        test_random_traffic(24, 24, 170);

        // drain: every predicted token must come out, then nothing more
        s_valid <= 1'b0;
        snk_stall_pct = 0;
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[bencode_stream_tokenizer_core] OK");
        end else begin
            $display("[bencode_stream_tokenizer_core] ERROR");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a lost token ends here
    initial begin
        #(2_400_000);
        $display("[bencode_stream_tokenizer_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
